### src/rrts_pkg.sv
// Shared types and codes for the round-robin task scheduler.
package rrts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int ID_W = 4;

  typedef enum logic [3:0] {
    OP_CREATE   = 4'd0,
    OP_SCHEDULE = 4'd1,
    OP_AWAKE    = 4'd2,
    OP_SUSPEND  = 4'd3,
    OP_DESTROY  = 4'd4,
    OP_STEAL    = 4'd5,
    OP_WAITER   = 4'd6,
    OP_RETRY    = 4'd7,
    OP_QUERY    = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCHED,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]      op;
    logic [ID_W-1:0] task_id;
    logic            start_running;
    logic            keep_waiter_asleep;
  } in_word_t;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] chosen_id;
    logic            task_running;
    logic            task_known;
    logic            release_waiter;
    logic            wakes_pending;
    logic            all_idle;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic write;
  } q_cmd_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### src/rrts_cell.sv
// One ready-queue slot: loads a pushed id or takes its neighbor's id on a shift.
module rrts_cell (
  input  logic                    clk,
  input  rrts_pkg::cell_ctrl_t    ctrl,
  input  logic [rrts_pkg::ID_W-1:0] next_data,
  input  logic [rrts_pkg::ID_W-1:0] load_data,
  output logic [rrts_pkg::ID_W-1:0] data
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= next_data;
    end
  end

endmodule

### src/rrts_queue.sv
// Ready queue as a chain of cells shifting toward the head.
module rrts_queue #(
  parameter int DEPTH = rrts_pkg::MAX_TASKS_DEF,
  localparam int PW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  rrts_pkg::q_cmd_t          cmd,
  input  logic [PW-1:0]             wr_pos,
  input  logic [rrts_pkg::ID_W-1:0] wr_data,
  output logic [rrts_pkg::ID_W-1:0] head
);

  logic [rrts_pkg::ID_W-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rrts_pkg::cell_ctrl_t      ctrl;
    logic [rrts_pkg::ID_W-1:0] nxt;

    assign ctrl.shift = cmd.shift;
    assign ctrl.load  = cmd.write && (wr_pos == PW'(i));
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = data[i+1];
    end

    rrts_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .next_data (nxt),
      .load_data (wr_data),
      .data      (data[i])
    );
  end

  assign head = data[0];

endmodule

### src/round_robin_task_scheduler_unit.sv
// Round-robin ready-queue task scheduler: control, task flags and queue chain.
// Simple ops go IDLE, FINISH, DONE; schedule pops entries in SCHED until a runnable head is
// found or the queue is empty. Suspend, destroy and create of a stolen id set up a walk in
// FINISH, move each queued entry past the head in WALK one slot a cycle, then FINISH again.
// One op at a time; busy is high until the result cycle ends, next word in the cycle after.
// Receiver cannot stall. Reset (rst, synchronous) empties the queue and clears all task flags.
module round_robin_task_scheduler_unit #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rrts_pkg::in_word_t  cmd,
  output logic                busy,
  output logic                done,
  output rrts_pkg::out_word_t result
);

  localparam int NF   = (MAX_TASKS < 16) ? MAX_TASKS : 16;
  localparam int FIW  = $clog2(NF);
  localparam int PW   = $clog2(MAX_TASKS);
  localparam int CNTW = $clog2(MAX_TASKS + 1);

  rrts_pkg::state_t state, state_next;

  logic [CNTW-1:0] count, count_next;
  logic [CNTW-1:0] walk_left, walk_left_next;
  logic            found, found_next;
  logic            drop_all, drop_all_next;
  logic [NF-1:0]   known, known_next;
  logic [NF-1:0]   susp, susp_next;
  logic [NF-1:0]   running, running_next;
  logic [NF-1:0]   early, early_next;
  logic [NF-1:0]   stolen, stolen_next;
  logic [NF-1:0]   waiter, waiter_next;

  rrts_pkg::in_word_t      cmd_r;
  logic                    r_ok, r_ok_next;
  logic [rrts_pkg::ID_W-1:0] r_chosen, r_chosen_next;
  logic                    r_trun, r_trun_next;
  logic                    r_tknown, r_tknown_next;
  logic                    r_rel, r_rel_next;

  rrts_pkg::q_cmd_t          q_cmd;
  logic [PW-1:0]             q_pos;
  logic [rrts_pkg::ID_W-1:0] q_wdata;
  logic [rrts_pkg::ID_W-1:0] q_head;

  logic            accept;
  logic            id_valid;
  logic [FIW-1:0]  idx;
  logic [FIW-1:0]  hidx;
  logic            full;
  logic [CNTW-1:0] cnt_m1;
  logic            head_match;
  logic            drop;
  logic            runnable;
  logic [NF-1:0]   cand;
  logic            cand_any;
  logic [FIW-1:0]  cand_idx;
  logic            need_walk;
  logic            walk_setup;

  rrts_queue #(.DEPTH(MAX_TASKS)) u_queue (
    .clk     (clk),
    .cmd     (q_cmd),
    .wr_pos  (q_pos),
    .wr_data (q_wdata),
    .head    (q_head)
  );

  assign accept     = start && !busy;
  assign id_valid   = 32'(cmd_r.task_id) < 32'(MAX_TASKS);
  assign idx        = cmd_r.task_id[FIW-1:0];
  assign hidx       = q_head[FIW-1:0];
  assign full       = count == CNTW'(MAX_TASKS);
  assign cnt_m1     = count - CNTW'(1);
  assign head_match = q_head == cmd_r.task_id;
  assign drop       = head_match && (drop_all || !found);
  assign runnable   = !stolen[hidx] && running[hidx];
  assign cand       = early & susp;
  assign cand_any   = |cand;

  always_comb begin
    cand_idx = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cand_idx = FIW'(i);
      end
    end
  end

  // walk needed for purge of a stolen id or removal of the first match
  always_comb begin
    need_walk = 1'b0;
    if (id_valid) begin
      case (cmd_r.op)
        rrts_pkg::OP_CREATE:  need_walk = !known[idx] && stolen[idx];
        rrts_pkg::OP_SUSPEND: need_walk = !early[idx] && known[idx];
        rrts_pkg::OP_DESTROY: need_walk = known[idx];
        default:              need_walk = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rrts_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.op == rrts_pkg::OP_SCHEDULE) begin
            state_next = rrts_pkg::ST_SCHED;
          end else begin
            state_next = rrts_pkg::ST_FINISH;
          end
        end
      end
      rrts_pkg::ST_WALK: begin
        if (walk_left == '0) begin
          state_next = rrts_pkg::ST_FINISH;
        end
      end
      rrts_pkg::ST_SCHED: begin
        if (count == '0 || runnable) begin
          state_next = rrts_pkg::ST_DONE;
        end
      end
      rrts_pkg::ST_FINISH: begin
        if (need_walk && walk_left == '0 && !found && !drop_all) begin
          state_next = rrts_pkg::ST_WALK;
        end else begin
          state_next = rrts_pkg::ST_DONE;
        end
      end
      rrts_pkg::ST_DONE: state_next = rrts_pkg::ST_IDLE;
      default:           state_next = rrts_pkg::ST_IDLE;
    endcase
  end

  // FINISH is entered twice when a walk is needed: first to set it up,
  // then after it with drop_all or found marking the walk as done.
  assign walk_setup = (state == rrts_pkg::ST_FINISH) && need_walk &&
                      walk_left == '0 && !found && !drop_all;

  always_comb begin
    count_next     = count;
    walk_left_next = walk_left;
    found_next     = found;
    drop_all_next  = drop_all;
    known_next     = known;
    susp_next      = susp;
    running_next   = running;
    early_next     = early;
    stolen_next    = stolen;
    waiter_next    = waiter;
    r_ok_next      = r_ok;
    r_chosen_next  = r_chosen;
    r_trun_next    = r_trun;
    r_tknown_next  = r_tknown;
    r_rel_next     = r_rel;
    q_cmd          = '0;
    q_pos          = cnt_m1[PW-1:0];
    q_wdata        = q_head;
    case (state)
      rrts_pkg::ST_IDLE: begin
        if (accept) begin
          walk_left_next = '0;
          found_next     = 1'b0;
          drop_all_next  = 1'b0;
          r_ok_next      = 1'b0;
          r_chosen_next  = '0;
          r_trun_next    = 1'b0;
          r_tknown_next  = 1'b0;
          r_rel_next     = 1'b0;
        end
      end
      rrts_pkg::ST_WALK: begin
        if (walk_left != '0) begin
          walk_left_next = walk_left - CNTW'(1);
          q_cmd.shift    = 1'b1;
          q_cmd.write    = !drop;
          if (drop) begin
            count_next = cnt_m1;
            found_next = 1'b1;
          end
        end else if (cmd_r.op == rrts_pkg::OP_CREATE) begin
          found_next = 1'b1;
        end else begin
          drop_all_next = 1'b1;
        end
      end
      rrts_pkg::ST_SCHED: begin
        if (count != '0) begin
          q_cmd.shift = 1'b1;
          q_cmd.write = runnable;
          if (runnable) begin
            r_ok_next     = 1'b1;
            r_chosen_next = q_head;
          end else begin
            count_next = cnt_m1;
            if (stolen[hidx]) begin
              stolen_next[hidx] = 1'b0;
            end else begin
              susp_next[hidx] = 1'b1;
            end
          end
        end
      end
      rrts_pkg::ST_FINISH: begin
        if (walk_setup) begin
          walk_left_next = count;
          drop_all_next  = cmd_r.op == rrts_pkg::OP_CREATE;
        end else if (cmd_r.op == rrts_pkg::OP_RETRY) begin
          if (cand_any && !full) begin
            q_cmd.write             = 1'b1;
            q_pos                   = count[PW-1:0];
            q_wdata                 = rrts_pkg::ID_W'(cand_idx);
            count_next              = count + CNTW'(1);
            running_next[cand_idx]  = 1'b1;
            susp_next[cand_idx]     = 1'b0;
            early_next[cand_idx]    = 1'b0;
            r_ok_next               = 1'b1;
            r_chosen_next           = rrts_pkg::ID_W'(cand_idx);
          end
        end else if (id_valid) begin
          case (cmd_r.op)
            rrts_pkg::OP_CREATE: begin
              if (!known[idx]) begin
                stolen_next[idx] = 1'b0;
                if (cmd_r.start_running) begin
                  if (!full) begin
                    q_cmd.write       = 1'b1;
                    q_pos             = count[PW-1:0];
                    q_wdata           = cmd_r.task_id;
                    count_next        = count + CNTW'(1);
                    known_next[idx]   = 1'b1;
                    running_next[idx] = 1'b1;
                    r_ok_next         = 1'b1;
                  end
                end else begin
                  susp_next[idx]    = 1'b1;
                  known_next[idx]   = 1'b1;
                  running_next[idx] = 1'b0;
                  r_ok_next         = 1'b1;
                end
              end
            end
            rrts_pkg::OP_AWAKE: begin
              if (susp[idx]) begin
                if (!full) begin
                  q_cmd.write       = 1'b1;
                  q_pos             = count[PW-1:0];
                  q_wdata           = cmd_r.task_id;
                  count_next        = count + CNTW'(1);
                  running_next[idx] = 1'b1;
                  susp_next[idx]    = 1'b0;
                  r_ok_next         = 1'b1;
                end
              end else begin
                early_next[idx] = 1'b1;
              end
            end
            rrts_pkg::OP_SUSPEND: begin
              if (early[idx]) begin
                early_next[idx] = 1'b0;
                r_ok_next       = 1'b1;
              end else if (known[idx] && found) begin
                running_next[idx] = 1'b0;
                susp_next[idx]    = 1'b1;
                r_ok_next         = 1'b1;
              end
            end
            rrts_pkg::OP_DESTROY: begin
              r_rel_next       = waiter[idx] && !cmd_r.keep_waiter_asleep;
              waiter_next[idx] = 1'b0;
              if (known[idx]) begin
                susp_next[idx]    = 1'b0;
                known_next[idx]   = 1'b0;
                running_next[idx] = 1'b0;
                r_ok_next         = 1'b1;
              end
            end
            rrts_pkg::OP_STEAL: begin
              if (known[idx]) begin
                known_next[idx]   = 1'b0;
                r_rel_next        = waiter[idx];
                waiter_next[idx]  = 1'b0;
                running_next[idx] = 1'b0;
                if (susp[idx]) begin
                  susp_next[idx] = 1'b0;
                end else begin
                  stolen_next[idx] = 1'b1;
                end
                r_ok_next = 1'b1;
              end
            end
            rrts_pkg::OP_WAITER: begin
              if (!waiter[idx]) begin
                waiter_next[idx] = 1'b1;
                r_ok_next        = 1'b1;
              end
            end
            rrts_pkg::OP_QUERY: begin
              r_tknown_next = known[idx];
              r_trun_next   = known[idx] && running[idx];
              r_ok_next     = known[idx];
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrts_pkg::ST_IDLE;
      count     <= '0;
      walk_left <= '0;
      found     <= 1'b0;
      drop_all  <= 1'b0;
      known     <= '0;
      susp      <= '0;
      running   <= '0;
      early     <= '0;
      stolen    <= '0;
      waiter    <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      walk_left <= walk_left_next;
      found     <= found_next;
      drop_all  <= drop_all_next;
      known     <= known_next;
      susp      <= susp_next;
      running   <= running_next;
      early     <= early_next;
      stolen    <= stolen_next;
      waiter    <= waiter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd;
    end
    r_ok     <= r_ok_next;
    r_chosen <= r_chosen_next;
    r_trun   <= r_trun_next;
    r_tknown <= r_tknown_next;
    r_rel    <= r_rel_next;
  end

  assign busy = state != rrts_pkg::ST_IDLE;
  assign done = state == rrts_pkg::ST_DONE;

  always_comb begin
    result.ok             = r_ok;
    result.chosen_id      = r_chosen;
    result.task_running   = r_trun;
    result.task_known     = r_tknown;
    result.release_waiter = r_rel;
    result.wakes_pending  = |early;
    result.all_idle       = (count == '0) && !(|susp);
  end

endmodule

### test/tb_round_robin_task_scheduler_unit.sv
// Self-checking testbench for the round-robin task scheduler unit.
module tb_round_robin_task_scheduler_unit;

  localparam int NT = 16;
  localparam int WATCH_LIMIT = 4000;

  logic clk;
  logic rst;
  logic start;
  rrts_pkg::in_word_t cmd;
  logic busy;
  logic done;
  rrts_pkg::out_word_t result;

  round_robin_task_scheduler_unit u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // scheduler state mirror
  logic [3:0] rq[$];
  logic [NT-1:0] known_m, susp_m, run_m, wake_m, stolen_m, waiter_m;

  rrts_pkg::out_word_t sched_results[$];
  int mismatches;
  int idle_cycles;

  function automatic void q_append(logic [3:0] id);
    rq.insert(rq.size(), id);
  endfunction

  function automatic void purge_id(logic [3:0] id);
    int i;
    i = 0;
    while (i < rq.size()) begin
      if (rq[i] == id) rq.delete(i);
      else i++;
    end
  endfunction

  function automatic void remove_first(logic [3:0] id);
    int i;
    for (i = 0; i < rq.size(); i++) begin
      if (rq[i] == id) begin
        rq.delete(i);
        return;
      end
    end
  endfunction

  function automatic bit in_queue(logic [3:0] id);
    foreach (rq[i]) if (rq[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic rrts_pkg::out_word_t predict_sched(rrts_pkg::in_word_t w);
    rrts_pkg::out_word_t r;
    logic [3:0] t;
    logic [3:0] id;
    bit found;
    r = '0;
    id = w.task_id;
    case (rrts_pkg::op_t'(w.op))
      rrts_pkg::OP_SCHEDULE: begin
        while (rq.size() > 0) begin
          t = rq.pop_front();
          if (stolen_m[t]) begin
            stolen_m[t] = 1'b0;
          end else if (!run_m[t]) begin
            susp_m[t] = 1'b1;
          end else begin
            q_append(t);
            r.ok = 1'b1;
            r.chosen_id = t;
            break;
          end
        end
      end
      rrts_pkg::OP_RETRY: begin
        found = 1'b0;
        for (int i = 0; i < NT && !found; i++) begin
          if (wake_m[i] && susp_m[i]) begin
            found = 1'b1;
            if (rq.size() < NT) begin
              q_append(4'(i));
              run_m[i] = 1'b1;
              susp_m[i] = 1'b0;
              wake_m[i] = 1'b0;
              r.ok = 1'b1;
              r.chosen_id = 4'(i);
            end
          end
        end
      end
      rrts_pkg::OP_CREATE: begin
        if (!known_m[id]) begin
          if (stolen_m[id]) begin
            purge_id(id);
            stolen_m[id] = 1'b0;
          end
          if (!w.start_running || rq.size() < NT) begin
            if (w.start_running) q_append(id);
            else susp_m[id] = 1'b1;
            known_m[id] = 1'b1;
            run_m[id] = w.start_running;
            r.ok = 1'b1;
          end
        end
      end
      rrts_pkg::OP_AWAKE: begin
        if (susp_m[id]) begin
          if (rq.size() < NT) begin
            q_append(id);
            run_m[id] = 1'b1;
            susp_m[id] = 1'b0;
            r.ok = 1'b1;
          end
        end else begin
          wake_m[id] = 1'b1;
        end
      end
      rrts_pkg::OP_SUSPEND: begin
        if (wake_m[id]) begin
          wake_m[id] = 1'b0;
          r.ok = 1'b1;
        end else if (known_m[id] && in_queue(id)) begin
          remove_first(id);
          run_m[id] = 1'b0;
          susp_m[id] = 1'b1;
          r.ok = 1'b1;
        end
      end
      rrts_pkg::OP_DESTROY: begin
        r.release_waiter = waiter_m[id] && !w.keep_waiter_asleep;
        waiter_m[id] = 1'b0;
        if (known_m[id]) begin
          remove_first(id);
          susp_m[id] = 1'b0;
          known_m[id] = 1'b0;
          run_m[id] = 1'b0;
          r.ok = 1'b1;
        end
      end
      rrts_pkg::OP_STEAL: begin
        if (known_m[id]) begin
          known_m[id] = 1'b0;
          r.release_waiter = waiter_m[id];
          waiter_m[id] = 1'b0;
          if (susp_m[id]) susp_m[id] = 1'b0;
          else stolen_m[id] = 1'b1;
          run_m[id] = 1'b0;
          r.ok = 1'b1;
        end
      end
      rrts_pkg::OP_WAITER: begin
        if (!waiter_m[id]) begin
          waiter_m[id] = 1'b1;
          r.ok = 1'b1;
        end
      end
      rrts_pkg::OP_QUERY: begin
        r.task_known = known_m[id];
        r.task_running = known_m[id] && run_m[id];
        r.ok = known_m[id];
      end
      default: ;
    endcase
    r.wakes_pending = |wake_m;
    r.all_idle = (rq.size() == 0) && (susp_m == '0);
    return r;
  endfunction

  task automatic send_word(logic [3:0] op, logic [3:0] id, logic sr, logic kw);
    rrts_pkg::in_word_t w;
    int gap;
    w.op = op;
    w.task_id = id;
    w.start_running = sr;
    w.keep_waiter_asleep = kw;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sched_results.insert(sched_results.size(), predict_sched(w));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (sched_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (sched_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", result);
      end else begin
        rrts_pkg::out_word_t e;
        e = sched_results.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ok=%b id=%0d run=%b known=%b rel=%b wk=%b idle=%b",
                     e.ok, e.chosen_id, e.task_running, e.task_known, e.release_waiter,
                     e.wakes_pending, e.all_idle,
                     " got ok=%b id=%0d run=%b known=%b rel=%b wk=%b idle=%b",
                     result.ok, result.chosen_id, result.task_running, result.task_known,
                     result.release_waiter, result.wakes_pending, result.all_idle);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= WATCH_LIMIT) begin
      $display("round_robin_task_scheduler_unit verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(rrts_pkg::OP_QUERY, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_SCHEDULE, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_RETRY, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_CREATE, 4'd0, 1'b1, 1'b0);
    send_word(rrts_pkg::OP_CREATE, 4'd15, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_CREATE, 4'd0, 1'b1, 1'b0);
    send_word(rrts_pkg::OP_AWAKE, 4'd3, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_SUSPEND, 4'd3, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_AWAKE, 4'd7, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_CREATE, 4'd7, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_RETRY, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_WAITER, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_WAITER, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_STEAL, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_CREATE, 4'd0, 1'b1, 1'b0);
    send_word(rrts_pkg::OP_STEAL, 4'd7, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_SCHEDULE, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_WAITER, 4'd9, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_DESTROY, 4'd9, 1'b0, 1'b1);
    send_word(rrts_pkg::OP_WAITER, 4'd9, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_DESTROY, 4'd9, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_SUSPEND, 4'd0, 1'b0, 1'b0);
    send_word(rrts_pkg::OP_QUERY, 4'd15, 1'b1, 1'b1);
    send_word(4'd15, 4'd15, 1'b1, 1'b1);
    send_word(4'd9, 4'd1, 1'b0, 1'b0);
  endtask

  // fill the queue to hit the full case
  task automatic test_queue_full();
    for (int i = 0; i < NT; i++) send_word(rrts_pkg::OP_CREATE, 4'(i), 1'b1, 1'b0);
    send_word(rrts_pkg::OP_AWAKE, 4'd0, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) send_word(rrts_pkg::OP_SCHEDULE, 4'd0, 1'b0, 1'b0);
    drain_results();
    for (int i = 0; i < NT; i++) send_word(rrts_pkg::OP_DESTROY, 4'(i), 1'b0, 1'b0);
  endtask

  task automatic test_random();
    logic [3:0] op;
    logic [3:0] id;
    int pick;
    for (int n = 0; n < 700; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) op = rrts_pkg::OP_SCHEDULE;
      else if (pick < 32) op = rrts_pkg::OP_CREATE;
      else if (pick < 44) op = rrts_pkg::OP_AWAKE;
      else if (pick < 56) op = rrts_pkg::OP_SUSPEND;
      else if (pick < 63) op = rrts_pkg::OP_DESTROY;
      else if (pick < 70) op = rrts_pkg::OP_STEAL;
      else if (pick < 77) op = rrts_pkg::OP_WAITER;
      else if (pick < 85) op = rrts_pkg::OP_RETRY;
      else if (pick < 97) op = rrts_pkg::OP_QUERY;
      else op = 4'($urandom_range(9, 15));
      id = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
      send_word(op, id, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      if (n == 350) drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    mismatches = 0;
    rq.delete();
    known_m = '0; susp_m = '0; run_m = '0;
    wake_m = '0; stolen_m = '0; waiter_m = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_queue_full();
    test_random();
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && sched_results.size() == 0) begin
      $display("round_robin_task_scheduler_unit verification clean");
    end else begin
      $display("round_robin_task_scheduler_unit verification failed");
    end
    $finish;
  end

endmodule

### round_robin_task_scheduler_unit.f
src/rrts_pkg.sv
src/rrts_cell.sv
src/rrts_queue.sv
src/round_robin_task_scheduler_unit.sv
test/tb_round_robin_task_scheduler_unit.sv
